FILE: rtl/aby_pkg.sv
// Shared types, constants and helpers for the alpha blend to YCbCr 4:2:2 writer.
`default_nettype none
package aby_pkg;

  localparam int WordsPerLineDefault = 320;

  localparam int AddrW  = 20;
  localparam int CoordW = 11;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 11;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    RegBgRed     = 3'd0,
    RegBgGreen   = 3'd1,
    RegBgBlue    = 3'd2,
    RegBufWidth  = 3'd3,
    RegBufHeight = 3'd4
  } cfg_reg_t;

  localparam logic [CoordW-1:0] BufWidthReset  = 11'd640;
  localparam logic [CoordW-1:0] BufHeightReset = 11'd480;

  localparam logic [7:0] AlphaOpaque = 8'hFF;

  // BT.601 integer coefficients.
  localparam int YNumW = 18;
  localparam int CNumW = 25;
  localparam logic [YNumW-1:0] YCoefR = 18'd299;
  localparam logic [YNumW-1:0] YCoefG = 18'd587;
  localparam logic [YNumW-1:0] YCoefB = 18'd114;
  localparam logic [CNumW-1:0] COffset  = 25'd12800000;
  localparam logic [CNumW-1:0] CCoefMain = 25'd50000;
  localparam logic [CNumW-1:0] CbCoefR = 25'd16874;
  localparam logic [CNumW-1:0] CbCoefG = 25'd33126;
  localparam logic [CNumW-1:0] CrCoefG = 25'd41869;
  localparam logic [CNumW-1:0] CrCoefB = 25'd8131;

  // Division by constants: q0 = (n * Recip) >> Shift undershoots the true
  // quotient by at most one, since n stays below 2**Shift.
  localparam logic [YNumW-1:0] YDiv = 18'd1000;
  localparam logic [CNumW-1:0] CDiv = 25'd100000;
  localparam int YShift = YNumW;
  localparam int CShift = CNumW;
  localparam int RecipW = 9;
  localparam logic [RecipW-1:0] YRecip = RecipW'((2 ** YShift) / 1000);
  localparam logic [RecipW-1:0] CRecip = RecipW'((2 ** CShift) / 100000);

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic [CoordW-1:0] dest_x;
    logic [CoordW-1:0] dest_y;
  } pix_in_t;

  typedef struct packed {
    logic [AddrW-1:0] word_addr;
    logic [31:0]      pixel_word;
  } pix_out_t;

  // Blended color and address handed to the conversion pipeline.
  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [AddrW-1:0] word_addr;
  } csc_in_t;

  // ((a+1)*c + (256-a)*bg) >> 8; the two weights sum to 257, so 17 bits hold it.
  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] c,
                                       input logic [7:0] bg);
    logic [8:0]  wf;
    logic [8:0]  wb;
    logic [16:0] sum;
    wf  = {1'b0, a} + 9'd1;
    wb  = 9'd256 - {1'b0, a};
    sum = 17'(wf) * 17'(c) + 17'(wb) * 17'(bg);
    return sum[15:8];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/aby_csc.sv
// Pipelined BT.601 color conversion and Y-Cb-Y-Cr word packing.
`default_nettype none
module aby_csc (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  aby_pkg::csc_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output aby_pkg::pix_out_t out_data
);

  localparam int YNumW = aby_pkg::YNumW;
  localparam int CNumW = aby_pkg::CNumW;
  localparam int RecipW = aby_pkg::RecipW;
  localparam int YProdW = YNumW + RecipW;
  localparam int CProdW = CNumW + RecipW;

  // Stage 2: numerators.
  logic                    s2_valid;
  logic                    s2_ready;
  logic [YNumW-1:0]        s2_y_num;
  logic [CNumW-1:0]        s2_cb_num;
  logic [CNumW-1:0]        s2_cr_num;
  logic [aby_pkg::AddrW-1:0] s2_addr;

  // Stage 3: estimated quotients.
  logic                    s3_valid;
  logic                    s3_ready;
  logic [YNumW-1:0]        s3_y_num;
  logic [CNumW-1:0]        s3_cb_num;
  logic [CNumW-1:0]        s3_cr_num;
  logic [7:0]              s3_y_q0;
  logic [7:0]              s3_cb_q0;
  logic [7:0]              s3_cr_q0;
  logic [aby_pkg::AddrW-1:0] s3_addr;

  // Stage 4: output register.
  logic                    s4_ready;

  logic [YNumW-1:0]  y_num_next;
  logic [CNumW-1:0]  cb_num_next;
  logic [CNumW-1:0]  cr_num_next;
  logic [YProdW-1:0] y_prod;
  logic [CProdW-1:0] cb_prod;
  logic [CProdW-1:0] cr_prod;
  logic [YNumW-1:0]  y_rem;
  logic [CNumW-1:0]  cb_rem;
  logic [CNumW-1:0]  cr_rem;
  logic [7:0]        y_q;
  logic [7:0]        cb_q;
  logic [7:0]        cr_q;

  assign s4_ready = !out_valid || out_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign in_ready = s2_ready;

  always_comb begin
    y_num_next = aby_pkg::YCoefR * YNumW'(in_data.red)
               + aby_pkg::YCoefG * YNumW'(in_data.green)
               + aby_pkg::YCoefB * YNumW'(in_data.blue);
    // Both chroma numerators stay at or above 50000, so no wrap occurs.
    cb_num_next = aby_pkg::COffset + aby_pkg::CCoefMain * CNumW'(in_data.blue)
                - aby_pkg::CbCoefR * CNumW'(in_data.red)
                - aby_pkg::CbCoefG * CNumW'(in_data.green);
    cr_num_next = aby_pkg::COffset + aby_pkg::CCoefMain * CNumW'(in_data.red)
                - aby_pkg::CrCoefG * CNumW'(in_data.green)
                - aby_pkg::CrCoefB * CNumW'(in_data.blue);
  end

  always_comb begin
    y_prod  = YProdW'(s2_y_num) * YProdW'(aby_pkg::YRecip);
    cb_prod = CProdW'(s2_cb_num) * CProdW'(aby_pkg::CRecip);
    cr_prod = CProdW'(s2_cr_num) * CProdW'(aby_pkg::CRecip);
  end

  always_comb begin
    y_rem  = s3_y_num - YNumW'(s3_y_q0) * aby_pkg::YDiv;
    cb_rem = s3_cb_num - CNumW'(s3_cb_q0) * aby_pkg::CDiv;
    cr_rem = s3_cr_num - CNumW'(s3_cr_q0) * aby_pkg::CDiv;
    y_q  = s3_y_q0 + 8'(y_rem >= aby_pkg::YDiv);
    cb_q = s3_cb_q0 + 8'(cb_rem >= aby_pkg::CDiv);
    cr_q = s3_cr_q0 + 8'(cr_rem >= aby_pkg::CDiv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_ready) s2_valid <= in_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_y_num  <= y_num_next;
      s2_cb_num <= cb_num_next;
      s2_cr_num <= cr_num_next;
      s2_addr   <= in_data.word_addr;
    end
    if (s3_ready) begin
      s3_y_num  <= s2_y_num;
      s3_cb_num <= s2_cb_num;
      s3_cr_num <= s2_cr_num;
      s3_y_q0   <= y_prod[aby_pkg::YShift +: 8];
      s3_cb_q0  <= cb_prod[aby_pkg::CShift +: 8];
      s3_cr_q0  <= cr_prod[aby_pkg::CShift +: 8];
      s3_addr   <= s2_addr;
    end
    if (s4_ready) begin
      out_data.word_addr  <= s3_addr;
      out_data.pixel_word <= {y_q, cb_q, y_q, cr_q};
    end
  end

  // The reciprocal estimate never overshoots and misses by at most one.
  a_y_est: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (y_rem < 2 * aby_pkg::YDiv) && (YNumW'(s3_y_q0) * aby_pkg::YDiv <= s3_y_num))
    else $error("luma quotient estimate out of range");

  a_c_est: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (cb_rem < 2 * aby_pkg::CDiv) && (cr_rem < 2 * aby_pkg::CDiv))
    else $error("chroma quotient estimate out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_ready |=> s2_valid && $stable(s2_y_num) && $stable(s2_addr))
    else $error("stalled request lost in stage two");

  a_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && s3_valid && s2_valid)
    else $error("input stalled while the pipeline has room");

endmodule
`default_nettype wire

FILE: rtl/alpha_blend_to_ycbcr422_writer.sv
// Top level: configuration registers, clipping, alpha blend and address stage.
//
//   channel | signals                                  | direction
//   src     | src_valid, src_ready, src (pix_in_t)     | pixel requests in
//   dst     | dst_valid, dst_ready, dst (pix_out_t)    | frame buffer word requests out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| register writes in
//
// One pixel enters per clock while src_ready is high; a kept pixel passes the blend/address,
// numerator, reciprocal and correction stage registers in that order before it appears at dst.
// Dropped pixels leave a bubble and produce no request. cfg_ready is always high.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
// A stall at dst fills the stages one by one; src_ready falls only when all are full.
`default_nettype none
module alpha_blend_to_ycbcr422_writer #(
  parameter int WORDS_PER_LINE = aby_pkg::WordsPerLineDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          src_valid,
  output logic                          src_ready,
  input  aby_pkg::pix_in_t              src,
  output logic                          dst_valid,
  input  logic                          dst_ready,
  output aby_pkg::pix_out_t             dst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aby_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [aby_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int CoordW = aby_pkg::CoordW;
  localparam int ProdW  = 2 * CoordW;

  logic [7:0]        bg_red;
  logic [7:0]        bg_green;
  logic [7:0]        bg_blue;
  logic [CoordW-1:0] buf_width;
  logic [CoordW-1:0] buf_height;

  logic              s1_valid;
  logic              s1_ready;
  aby_pkg::csc_in_t  s1;
  aby_pkg::csc_in_t  s1_next;
  logic              keep;
  logic [ProdW-1:0]  addr_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_red     <= 8'd0;
      bg_green   <= 8'd0;
      bg_blue    <= 8'd0;
      buf_width  <= aby_pkg::BufWidthReset;
      buf_height <= aby_pkg::BufHeightReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        aby_pkg::RegBgRed:     bg_red     <= cfg_data[7:0];
        aby_pkg::RegBgGreen:   bg_green   <= cfg_data[7:0];
        aby_pkg::RegBgBlue:    bg_blue    <= cfg_data[7:0];
        aby_pkg::RegBufWidth:  buf_width  <= cfg_data;
        aby_pkg::RegBufHeight: buf_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    keep = (src.dest_x < buf_width) && (src.dest_y < buf_height) && (src.alpha != 8'd0);
    addr_full = ProdW'(src.dest_y) * ProdW'(WORDS_PER_LINE)
              + ProdW'(src.dest_x[CoordW-1:1]);
    s1_next.word_addr = addr_full[aby_pkg::AddrW-1:0];
    if (src.alpha == aby_pkg::AlphaOpaque) begin
      s1_next.red   = src.red;
      s1_next.green = src.green;
      s1_next.blue  = src.blue;
    end else begin
      s1_next.red   = aby_pkg::blend(src.alpha, src.red, bg_red);
      s1_next.green = aby_pkg::blend(src.alpha, src.green, bg_green);
      s1_next.blue  = aby_pkg::blend(src.alpha, src.blue, bg_blue);
    end
  end

  assign src_ready = s1_ready;

  logic csc_ready;
  assign s1_ready = !s1_valid || csc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= src_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) s1 <= s1_next;
  end

  aby_csc u_csc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (csc_ready),
    .in_data   (s1),
    .out_valid (dst_valid),
    .out_ready (dst_ready),
    .out_data  (dst)
  );

endmodule
`default_nettype wire
